### hdl/ncc_pkg.sv
// Shared constants for the nearest centroid classifier.
package ncc_pkg;

  // Configuration port: 36-bit centre data with a 3-bit centre index.
  localparam int CFG_W     = 36;
  localparam int CFG_IDX_W = 3;

  // Width of the result index (up to eight centres).
  localparam int IDX_W = 3;

  // Defaults for the top-level parameters.
  localparam int DEF_NUM_CENTERS = 6;
  localparam int DEF_COORD_BITS  = 12;

  // Square root digits resolved per pipeline stage.
  localparam int SQRT_STEPS = 4;

endpackage

### hdl/nearest_centroid_classifier.sv
// Nearest centroid classifier: pipelined distance, square root and argmin.
//
//  channel | signals                                  | direction | beat
//  --------+------------------------------------------+-----------+---------------------
//  in      | in_valid, in_stall, sample_x/y/z         | in        | valid & !in_stall
//  out     | out_valid, out_stall, nearest_index      | out       | valid & !out_stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| in        | valid & ready
//
// Throughput is one sample per cycle while the output is not stalled.
// The pipe holds difference, square and sum stages, then the digit-by-digit
// square root at four digits per stage, then a registered min tree. A stall
// on a valid output freezes the whole pipe; in_stall follows from it
// combinationally. Reset clears the valid bits and sets every centre to
// zero. cfg_ready is always high.
module nearest_centroid_classifier import ncc_pkg::*; #(
  parameter int NUM_CENTERS = DEF_NUM_CENTERS,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // sample beat
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] sample_x,
  input  logic [COORD_BITS-1:0] sample_y,
  input  logic [COORD_BITS-1:0] sample_z,
  // result beat
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IDX_W-1:0]      nearest_index,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int PACK_W    = 3 * COORD_BITS;
  localparam int EXT_W     = (PACK_W > CFG_W) ? PACK_W : CFG_W;
  localparam int SQ_W      = 2 * COORD_BITS;
  localparam int SUM_W     = 2 * COORD_BITS + 2;
  localparam int ROOT_W    = COORD_BITS + 1;
  localparam int SQ_STAGES = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;
  localparam int RSTEPS    = SQ_STAGES * SQRT_STEPS;
  localparam int RAD_W     = 2 * RSTEPS;
  localparam int REM_W     = RSTEPS + 3;
  localparam int LEVELS    = $clog2(NUM_CENTERS);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SQ_W-1:0]       sq_t;
  typedef logic [REM_W-1:0]      rem_t;
  typedef logic [RSTEPS-1:0]     root_t;
  typedef logic [RAD_W-1:0]      rad_t;
  typedef logic [ROOT_W-1:0]     dist_t;

  // Pipeline advance: the output register is free or is being taken.
  logic adv;
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------
  // Centre registers
  // ---------------------------------------------------------------------
  logic [PACK_W-1:0] center [NUM_CENTERS];
  logic [EXT_W-1:0]  cfg_ext;

  assign cfg_ext = EXT_W'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CENTERS; k++) begin
        center[k] <= '0;
      end
    end else if (cfg_valid) begin
      // indexes past the last centre are dropped
      for (int k = 0; k < NUM_CENTERS; k++) begin
        if (cfg_index == CFG_IDX_W'(k)) begin
          center[k] <= cfg_ext[PACK_W-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: absolute axis differences
  // ---------------------------------------------------------------------
  coord_t samp [3];
  coord_t dif_next [NUM_CENTERS][3];
  coord_t dif      [NUM_CENTERS][3];
  logic   v_dif;

  assign samp[0] = sample_x;
  assign samp[1] = sample_y;
  assign samp[2] = sample_z;

  always_comb begin
    coord_t c;
    for (int k = 0; k < NUM_CENTERS; k++) begin
      for (int a = 0; a < 3; a++) begin
        c = center[k][a*COORD_BITS +: COORD_BITS];
        dif_next[k][a] = (samp[a] >= c) ? (samp[a] - c) : (c - samp[a]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: squares
  // ---------------------------------------------------------------------
  sq_t  sq [NUM_CENTERS][3];
  logic v_sq;

  // ---------------------------------------------------------------------
  // Stage 3 and on: sum, then square root digits
  // ---------------------------------------------------------------------
  rem_t  st_rem      [SQ_STAGES+1][NUM_CENTERS];
  root_t st_q        [SQ_STAGES+1][NUM_CENTERS];
  rad_t  st_rad      [SQ_STAGES+1][NUM_CENTERS];
  rem_t  st_rem_next [SQ_STAGES+1][NUM_CENTERS];
  root_t st_q_next   [SQ_STAGES+1][NUM_CENTERS];
  rad_t  st_rad_next [SQ_STAGES+1][NUM_CENTERS];
  logic [SQ_STAGES:0] st_v;

  always_comb begin
    rem_t  rem;
    rem_t  trial;
    root_t q;
    rad_t  rad;
    // sum of squares seeds the root recurrence
    for (int k = 0; k < NUM_CENTERS; k++) begin
      st_rem_next[0][k] = '0;
      st_q_next[0][k]   = '0;
      st_rad_next[0][k] = RAD_W'(SUM_W'(sq[k][0]) + SUM_W'(sq[k][1]) + SUM_W'(sq[k][2]));
    end
    // restoring square root, two radicand bits per digit
    for (int s = 1; s <= SQ_STAGES; s++) begin
      for (int k = 0; k < NUM_CENTERS; k++) begin
        rem = st_rem[s-1][k];
        q   = st_q[s-1][k];
        rad = st_rad[s-1][k];
        for (int j = 0; j < SQRT_STEPS; j++) begin
          rem   = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
          trial = REM_W'({q, 2'b01});
          if (rem >= trial) begin
            rem = rem - trial;
            q   = {q[RSTEPS-2:0], 1'b1};
          end else begin
            q   = {q[RSTEPS-2:0], 1'b0};
          end
          rad = rad << 2;
        end
        st_rem_next[s][k] = rem;
        st_q_next[s][k]   = q;
        st_rad_next[s][k] = rad;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Min tree: pairwise compare per level, lower index wins on a tie
  // ---------------------------------------------------------------------
  dist_t            tr_d      [LEVELS][NUM_CENTERS];
  logic [IDX_W-1:0] tr_i      [LEVELS][NUM_CENTERS];
  dist_t            tr_d_next [LEVELS][NUM_CENTERS];
  logic [IDX_W-1:0] tr_i_next [LEVELS][NUM_CENTERS];
  logic [LEVELS-1:0] tr_v;

  always_comb begin
    int               n_src;
    int               n_dst;
    int               lp;
    int               ia;
    int               ib;
    dist_t            da;
    dist_t            db;
    logic [IDX_W-1:0] xa;
    logic [IDX_W-1:0] xb;
    for (int l = 0; l < LEVELS; l++) begin
      n_src = (NUM_CENTERS + (1 << l) - 1) >> l;
      n_dst = (NUM_CENTERS + (2 << l) - 1) >> (l + 1);
      lp    = (l == 0) ? 0 : l - 1;
      for (int s = 0; s < NUM_CENTERS; s++) begin
        ia = (2 * s < NUM_CENTERS) ? 2 * s : 0;
        ib = (2 * s + 1 < NUM_CENTERS) ? 2 * s + 1 : ia;
        if (l == 0) begin
          da = st_q[SQ_STAGES][ia][ROOT_W-1:0];
          db = st_q[SQ_STAGES][ib][ROOT_W-1:0];
          xa = IDX_W'(ia);
          xb = IDX_W'(ib);
        end else begin
          da = tr_d[lp][ia];
          db = tr_d[lp][ib];
          xa = tr_i[lp][ia];
          xb = tr_i[lp][ib];
        end
        if (s >= n_dst) begin
          tr_d_next[l][s] = '0;
          tr_i_next[l][s] = '0;
        end else if ((2 * s + 1 < n_src) && (db < da)) begin
          tr_d_next[l][s] = db;
          tr_i_next[l][s] = xb;
        end else begin
          tr_d_next[l][s] = da;
          tr_i_next[l][s] = xa;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Valid bits
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v_dif <= 1'b0;
      v_sq  <= 1'b0;
      st_v  <= '0;
      tr_v  <= '0;
    end else if (adv) begin
      v_dif <= in_valid;
      v_sq  <= v_dif;
      st_v  <= {st_v[SQ_STAGES-1:0], v_sq};
      for (int l = 0; l < LEVELS; l++) begin
        tr_v[l] <= (l == 0) ? st_v[SQ_STAGES] : tr_v[(l == 0) ? 0 : l - 1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      dif <= dif_next;
      for (int k = 0; k < NUM_CENTERS; k++) begin
        for (int a = 0; a < 3; a++) begin
          sq[k][a] <= SQ_W'(dif[k][a]) * SQ_W'(dif[k][a]);
        end
      end
      st_rem <= st_rem_next;
      st_q   <= st_q_next;
      st_rad <= st_rad_next;
      tr_d   <= tr_d_next;
      tr_i   <= tr_i_next;
    end
  end

  assign out_valid     = tr_v[LEVELS-1];
  assign nearest_index = tr_i[LEVELS-1][0];

`ifndef ASSERT_OFF
  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // the winner is always one of the configured centres
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (nearest_index < IDX_W'(NUM_CENTERS)))
    else $error("nearest_index out of range");

  // a frozen pipe keeps every valid bit in place
  a_frozen_pipe: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({v_dif, v_sq, st_v, tr_v}))
    else $error("valid bits moved during a stall");

  // root remainder bound: 0 <= n - q*q <= 2q
  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    st_v[SQ_STAGES] |-> (st_rem[SQ_STAGES][0] <= REM_W'({st_q[SQ_STAGES][0], 1'b0})))
    else $error("square root remainder too large");
`endif

endmodule

### verif/ncc_checker.sv
// Checker for the nearest centroid classifier: tracks center writes, predicts, compares results.
`timescale 1ns / 1ps

module ncc_checker import ncc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [DEF_COORD_BITS-1:0]  sample_x,
  input  logic [DEF_COORD_BITS-1:0]  sample_y,
  input  logic [DEF_COORD_BITS-1:0]  sample_z,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [IDX_W-1:0]           nearest_index,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  output int                         errors,
  output int                         pending,
  output int                         results
);

  localparam int CW = DEF_COORD_BITS;
  localparam int NC = DEF_NUM_CENTERS;

  // Local copy of the center registers and the queue of predicted winners.
  logic [CFG_W-1:0] centers [NC];
  logic [IDX_W-1:0] expected_index [$];
  int mismatch_count = 0;
  int pending_count  = 0;
  int result_count   = 0;

  assign errors  = mismatch_count;
  assign pending = pending_count;
  assign results = result_count;

  // floor(sqrt(n)): float estimate, then nudged onto the exact integer root
  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r;
    r = $rtoi($sqrt(real'(n)));
    while (r * r > n) r = r - 1;
    while ((r + 1) * (r + 1) <= n) r = r + 1;
    return r;
  endfunction

  // Index of the center with the smallest truncated distance, lowest on ties
  function automatic logic [IDX_W-1:0] nearest_center(input logic [CW-1:0] sx,
                                                      input logic [CW-1:0] sy,
                                                      input logic [CW-1:0] sz);
    logic [IDX_W-1:0] winner;
    logic [CW-1:0] cx, cy, cz;
    longint unsigned dx, dy, dz, root_d, best;
    winner = '0;
    best   = 0;
    for (int k = 0; k < NC; k++) begin
      cx = centers[k][CW-1:0];
      cy = centers[k][2*CW-1:CW];
      cz = centers[k][3*CW-1:2*CW];
      dx = (sx >= cx) ? longint'(sx - cx) : longint'(cx - sx);
      dy = (sy >= cy) ? longint'(sy - cy) : longint'(cy - sy);
      dz = (sz >= cz) ? longint'(sz - cz) : longint'(cz - sz);
      root_d = floor_root(dx * dx + dy * dy + dz * dz);
      if (k == 0 || root_d < best) begin
        best   = root_d;
        winner = k[IDX_W-1:0];
      end
    end
    return winner;
  endfunction

  // Watch all three channels on each edge
  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NC; k++) centers[k] = '0;
      expected_index.delete();
    end else begin
      // result beat: compare against the oldest prediction
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_index.size() == 0) begin
          $error("nearest_index: expected no result, actual %0d", nearest_index);
          mismatch_count++;
        end else begin
          if (nearest_index !== expected_index[0]) begin
            $error("nearest_index: expected %0d, actual %0d",
                   expected_index[0], nearest_index);
            mismatch_count++;
          end
          void'(expected_index.pop_front());
        end
      end
      // sample beat: predict with the current centers
      if (in_valid && !in_stall)
        expected_index.push_back(nearest_center(sample_x, sample_y, sample_z));
      // register write beat; indexes past the last center are dropped
      if (cfg_valid && cfg_ready && cfg_index < NC)
        centers[cfg_index] = cfg_data;
    end
    pending_count = expected_index.size();
  end

endmodule

### verif/tb_nearest_centroid_classifier.sv
// Testbench top for the nearest centroid classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_nearest_centroid_classifier;
  import ncc_pkg::*;

  localparam int            CW         = DEF_COORD_BITS;
  localparam int            NC         = DEF_NUM_CENTERS;
  localparam logic [CW-1:0] CMAX       = '1;
  localparam int            PIPE_DEPTH = 10;
  localparam int            RAND_SETS  = 8;
  localparam int            SET_ITEMS  = 125;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CW-1:0]        sample_x = '0;
  logic [CW-1:0]        sample_y = '0;
  logic [CW-1:0]        sample_z = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [IDX_W-1:0]     nearest_index;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int errors, pending, results;
  int settings = 0;
  int sent = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  // Center setting to load next
  logic [CFG_W-1:0] plan [NC];

  always #4 clk = ~clk;

  nearest_centroid_classifier i_dut (
    .clk, .rst,
    .in_valid, .in_stall, .sample_x, .sample_y, .sample_z,
    .out_valid, .out_stall, .nearest_index,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ncc_checker i_checker (
    .clk, .rst,
    .in_valid, .in_stall, .sample_x, .sample_y, .sample_z,
    .out_valid, .out_stall, .nearest_index,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending, .results
  );

  function automatic logic [CFG_W-1:0] pack_center(input logic [CW-1:0] x,
                                                   input logic [CW-1:0] y,
                                                   input logic [CW-1:0] z);
    return {z, y, x};
  endfunction

  // Random offset around v, clamped to the coordinate range
  function automatic logic [CW-1:0] jitter(input logic [CW-1:0] v, input int span);
    int t;
    t = int'(v) - span + int'($urandom_range(0, 2 * span));
    if (t < 0) t = 0;
    if (t > int'(CMAX)) t = int'(CMAX);
    return t[CW-1:0];
  endfunction

  // One sample beat, after a random gap unless tx_calm is set
  task automatic send_sample(input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic [CW-1:0] z);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_x <= x;
    sample_y <= y;
    sample_z <= z;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Stop sending and let the pipe drain completely
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Write every center from plan, then one write to an unused index
  task automatic load_plan();
    for (int k = 0; k < NC; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= k[CFG_IDX_W-1:0];
      cfg_data  <= plan[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'($urandom_range(NC, (1 << CFG_IDX_W) - 1));
    cfg_data  <= CFG_W'({$urandom, $urandom});
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Build a random center setting of the given flavor
  task automatic make_plan(input int flavor);
    logic [CW-1:0] hx, hy, hz;
    hx = CW'($urandom);
    hy = CW'($urandom);
    hz = CW'($urandom);
    for (int k = 0; k < NC; k++) begin
      case (flavor)
        0: plan[k] = CFG_W'({$urandom, $urandom});
        // tight cluster: many truncated ties
        1: plan[k] = pack_center(jitter(hx, 3), jitter(hy, 3), jitter(hz, 3));
        // repeated centers: equal distances resolve to the lower index
        2: begin
          if (k > 0 && $urandom_range(0, 1) == 1) plan[k] = plan[k - 1];
          else plan[k] = CFG_W'({$urandom, $urandom});
        end
        // coordinates at the range limits only
        default: plan[k] = pack_center($urandom_range(0, 1) ? CMAX : '0,
                                       $urandom_range(0, 1) ? CMAX : '0,
                                       $urandom_range(0, 1) ? CMAX : '0);
      endcase
    end
  endtask

  // Random sample, biased toward the neighborhood of the loaded centers
  task automatic send_random();
    int pick, a, b;
    logic [CW-1:0] x, y, z;
    pick = $urandom_range(0, 9);
    a = $urandom_range(0, NC - 1);
    b = $urandom_range(0, NC - 1);
    x = CW'($urandom);
    y = CW'($urandom);
    z = CW'($urandom);
    if (pick <= 4) begin
      case ($urandom_range(0, 2))
        0: a = a;
        default: ;
      endcase
      x = jitter(plan[a][CW-1:0], pick <= 1 ? 3 : (pick <= 3 ? 40 : 400));
      y = jitter(plan[a][2*CW-1:CW], pick <= 1 ? 3 : (pick <= 3 ? 40 : 400));
      z = jitter(plan[a][3*CW-1:2*CW], pick <= 1 ? 3 : (pick <= 3 ? 40 : 400));
    end else if (pick == 8) begin
      x = $urandom_range(0, 1) ? CMAX : '0;
      y = $urandom_range(0, 1) ? CMAX : '0;
      z = $urandom_range(0, 1) ? CMAX : '0;
    end else if (pick == 9) begin
      // midway between two centers: distances nearly equal
      x = CW'((int'(plan[a][CW-1:0]) + int'(plan[b][CW-1:0])) / 2);
      y = CW'((int'(plan[a][2*CW-1:CW]) + int'(plan[b][2*CW-1:CW])) / 2);
      z = CW'((int'(plan[a][3*CW-1:2*CW]) + int'(plan[b][3*CW-1:2*CW])) / 2);
    end
    send_sample(x, y, z);
  endtask

  // Result side: random stall before each beat unless rx_calm is set
  initial begin : result_sink
    int hold;
    forever begin
      hold = rx_calm ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("nearest_centroid_classifier test failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // All centers zero after reset: everything maps to index 0
    send_sample('0, '0, '0);
    send_sample(CMAX, CMAX, CMAX);
    send_sample(12'hAAA, 12'h555, 12'hFFF);
    drain();

    // Corners and middle of the cube
    plan[0] = pack_center('0, '0, '0);
    plan[1] = pack_center(CMAX, CMAX, CMAX);
    plan[2] = pack_center(CMAX, '0, '0);
    plan[3] = pack_center('0, CMAX, '0);
    plan[4] = pack_center('0, '0, CMAX);
    plan[5] = pack_center(12'h800, 12'h800, 12'h800);
    load_plan();
    for (int k = 0; k < NC; k++)
      send_sample(plan[k][CW-1:0], plan[k][2*CW-1:CW], plan[k][3*CW-1:2*CW]);
    send_sample(12'h7FF, '0, '0);
    send_sample(12'h800, '0, '0);
    send_sample(12'h555, 12'hAAA, 12'h555);
    send_sample(CMAX, CMAX, '0);
    drain();

    // Truncated tie: centers 1 and 2 are truly closer than center 0, but all three truncate to 2
    plan[0] = pack_center(12'd102, 12'd101, 12'd100);
    plan[1] = pack_center(12'd102, 12'd100, 12'd100);
    plan[2] = pack_center(12'd98, 12'd100, 12'd100);
    plan[3] = pack_center(CMAX, CMAX, CMAX);
    plan[4] = pack_center(CMAX, '0, CMAX);
    plan[5] = pack_center('0, CMAX, CMAX);
    load_plan();
    send_sample(12'd100, 12'd100, 12'd100);
    send_sample(12'd101, 12'd100, 12'd100);
    send_sample(12'd100, 12'd101, 12'd100);
    drain();

    // Random phases over the center flavors, idling style changing as we go
    for (int s = 0; s < RAND_SETS; s++) begin
      make_plan(s % 4);
      load_plan();
      for (int n = 0; n < SET_ITEMS; n++) begin
        if (n % 40 == 0) begin
          tx_calm = ($urandom_range(0, 3) == 0);
          rx_calm = ($urandom_range(0, 3) == 0);
        end
        send_random();
      end
      drain();
    end

    $display("Sent %0d samples over %0d center settings; %0d results checked.",
             sent, settings, results);
    if (errors == 0) begin
      $display("nearest_centroid_classifier test passed");
    end else begin
      $display("nearest_centroid_classifier test failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/ncc_pkg.sv
hdl/nearest_centroid_classifier.sv
verif/ncc_checker.sv
verif/tb_nearest_centroid_classifier.sv
